// ----- sv/countdown_effect_table_core_macros.svh -----
// Assertion macros for the countdown effect table.
// CDET_ASSERT_CLK takes an explicit clock and active-low reset,
// CDET_ASSERT uses the block's own clk_i and rst_ni.
`ifndef COUNTDOWN_EFFECT_TABLE_CORE_MACROS_SVH
`define COUNTDOWN_EFFECT_TABLE_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define CDET_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CDET_ASSERT(lbl, prop, msg) \
  `CDET_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define CDET_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define CDET_ASSERT(lbl, prop, msg)
`endif

`endif

// ----- sv/cdet_pkg.sv -----
package cdet_pkg;

  // Table geometry
  localparam int unsigned Depth   = 16;
  localparam int unsigned IdBits  = 8;
  // Stored id width: the id port carries eight bits
  localparam int unsigned IdKeepW = (IdBits < 8) ? IdBits : 8;
  localparam int unsigned CntW    = $clog2(Depth + 1);

  // Input item kinds
  typedef enum logic [1:0] {
    KindAdd    = 2'd0,
    KindTick   = 2'd1,
    KindCancel = 2'd2
  } kind_e;

  // Result codes
  typedef enum logic [2:0] {
    EvAdded   = 3'd0,
    EvFull    = 3'd1,
    EvExpired = 3'd2,
    EvTickSum = 3'd3,
    EvCancSum = 3'd4
  } event_e;

  // One table entry
  typedef struct packed {
    logic [IdKeepW-1:0] id;
    logic [1:0]         owner;
    logic [3:0]         x;
    logic [3:0]         y;
    logic [7:0]         turns;
  } entry_t;

  // Per-cycle command to every cell of the chain
  typedef struct packed {
    logic shift;   // move the row one place towards the head, feed at the tail
    logic append;  // write the feed into the first free cell
  } cell_ctrl_t;

endpackage

// ----- sv/cdet_cell.sv -----
// One slot of the table. Holds a valid bit and an entry; on a shift it takes
// its upper neighbour, or the feed if it is the current tail.
module cdet_cell import cdet_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       prv_valid_i,
  input  logic       nxt_valid_i,
  input  entry_t     nxt_entry_i,
  input  logic       feed_valid_i,
  input  entry_t     feed_entry_i,
  output logic       valid_o,
  output entry_t     entry_o
);

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;

  // Next-state selection from neighbours and feed
  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      if (nxt_valid_i) begin
        valid_d = 1'b1;
        entry_d = nxt_entry_i;
      end else if (valid_q) begin
        valid_d = feed_valid_i;
        entry_d = feed_entry_i;
      end
    end else if (ctrl_i.append) begin
      if (!valid_q && prv_valid_i) begin
        valid_d = 1'b1;
        entry_d = feed_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Entry payload carries no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign valid_o = valid_q;
  assign entry_o = entry_q;

endmodule

// ----- sv/countdown_effect_table_core.sv -----
// Channel | Direction | Handshake              | Beat
// --------+-----------+------------------------+---------------------------------------
// in      | input     | in_valid_i/in_ready_o   | kind, effect_id, owner, target, turns
// out     | output    | out_valid_o/out_ready_i | event_res, id, owner, x, y, count, last
//
// Add: result registered in StAdd, next beat taken the cycle after.
// Tick and cancel: StScan passes the n stored entries, one entry leaving the head
// of the cell row per cycle unless stalled, then StSum registers the summary.
// Reset clears every valid bit and the control; entry payload is not reset.
// A tick stalls on each expired entry while the output register is held full;
// a new beat is taken once the previous item's last result is registered.
`include "countdown_effect_table_core_macros.svh"

module countdown_effect_table_core import cdet_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [7:0]  effect_id_i,
  input  logic [1:0]  owner_i,
  input  logic [3:0]  target_x_i,
  input  logic [3:0]  target_y_i,
  input  logic [7:0]  turns_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  event_res_o,
  output logic [7:0]  out_id_o,
  output logic [1:0]  out_owner_o,
  output logic [3:0]  out_x_o,
  output logic [3:0]  out_y_o,
  output logic [CntW-1:0] count_o,
  output logic        last_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StAdd  = 4'b0010,
    StScan = 4'b0100,
    StSum  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  entry_t            req_q, req_d;
  logic              tick_q, tick_d;
  logic [CntW-1:0]   steps_q, steps_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   fill_q, fill_d;

  logic [Depth-1:0]  valid_vec;
  entry_t            entries [Depth];
  cell_ctrl_t        ctrl;
  logic              feed_valid;
  entry_t            feed_entry;

  logic              out_valid_q;
  logic [2:0]        ev_q, ev_d;
  logic [7:0]        oid_q, oid_d;
  logic [1:0]        oown_q, oown_d;
  logic [3:0]        ox_q, ox_d;
  logic [3:0]        oy_q, oy_d;
  logic [CntW-1:0]   ocnt_q, ocnt_d;
  logic              olast_q, olast_d;
  logic              out_load;

  logic              emit_ok;
  logic              in_acc;
  entry_t            head;
  logic              drop;
  logic              full;

  // Cell row
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic   prv_v;
    logic   nxt_v;
    entry_t nxt_e;
    if (i == 0) begin : g_first
      assign prv_v = 1'b1;
    end else begin : g_mid
      assign prv_v = valid_vec[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign nxt_v = 1'b0;
      assign nxt_e = entries[i];
    end else begin : g_inner
      assign nxt_v = valid_vec[i+1];
      assign nxt_e = entries[i+1];
    end
    cdet_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .prv_valid_i  (prv_v),
      .nxt_valid_i  (nxt_v),
      .nxt_entry_i  (nxt_e),
      .feed_valid_i (feed_valid),
      .feed_entry_i (feed_entry),
      .valid_o      (valid_vec[i]),
      .entry_o      (entries[i])
    );
  end

  assign head     = entries[0];
  assign full     = valid_vec[Depth-1];
  assign emit_ok  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign in_acc   = in_valid_i && in_ready_o;

  // Head decision: expiry on tick, id and owner match on cancel
  assign drop = tick_q ? (head.turns <= 8'd1)
                       : ((head.id == req_q.id) && (head.owner == req_q.owner));

  // Sequencer
  always_comb begin
    state_d    = state_q;
    req_d      = req_q;
    tick_d     = tick_q;
    steps_d    = steps_q;
    cnt_d      = cnt_q;
    fill_d     = fill_q;
    ctrl       = '0;
    feed_valid = 1'b0;
    feed_entry = req_q;
    out_load   = 1'b0;
    ev_d       = EvAdded;
    oid_d      = '0;
    oown_d     = '0;
    ox_d       = '0;
    oy_d       = '0;
    ocnt_d     = '0;
    olast_d    = 1'b0;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          req_d.id    = effect_id_i[IdKeepW-1:0];
          req_d.owner = owner_i;
          req_d.x     = target_x_i;
          req_d.y     = target_y_i;
          req_d.turns = turns_i;
          steps_d     = fill_q;
          cnt_d       = '0;
          case (kind_i)
            KindAdd: begin
              state_d = StAdd;
            end
            KindTick: begin
              tick_d  = 1'b1;
              state_d = StScan;
            end
            KindCancel: begin
              tick_d  = 1'b0;
              state_d = StScan;
            end
            default: begin
              state_d = StIdle;
            end
          endcase
        end
      end

      StAdd: begin
        if (emit_ok) begin
          out_load = 1'b1;
          olast_d  = 1'b1;
          if (full) begin
            ev_d = EvFull;
          end else begin
            ev_d        = EvAdded;
            ctrl.append = 1'b1;
            feed_valid  = 1'b1;
            fill_d      = fill_q + CntW'(1);
          end
          state_d = StIdle;
        end
      end

      StScan: begin
        if (steps_q == '0) begin
          state_d = StSum;
        end else if (!(tick_q && drop) || emit_ok) begin
          // Head leaves the row; survivors re-enter at the tail
          ctrl.shift  = 1'b1;
          feed_valid  = !drop;
          feed_entry  = head;
          if (tick_q) begin
            feed_entry.turns = head.turns - 8'd1;
          end
          steps_d = steps_q - CntW'(1);
          if (drop) begin
            cnt_d  = cnt_q + CntW'(1);
            fill_d = fill_q - CntW'(1);
          end
          if (tick_q && drop) begin
            out_load = 1'b1;
            ev_d     = EvExpired;
            oid_d    = 8'(head.id);
            oown_d   = head.owner;
            ox_d     = head.x;
            oy_d     = head.y;
          end
        end
      end

      StSum: begin
        if (emit_ok) begin
          out_load = 1'b1;
          ev_d     = tick_q ? EvTickSum : EvCancSum;
          ocnt_d   = cnt_q;
          olast_d  = 1'b1;
          state_d  = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      fill_q      <= '0;
      steps_q     <= '0;
      cnt_q       <= '0;
      tick_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      steps_q <= steps_d;
      cnt_q   <= cnt_d;
      tick_q  <= tick_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload
  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (out_load) begin
      ev_q    <= ev_d;
      oid_q   <= oid_d;
      oown_q  <= oown_d;
      ox_q    <= ox_d;
      oy_q    <= oy_d;
      ocnt_q  <= ocnt_d;
      olast_q <= olast_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign event_res_o = ev_q;
  assign out_id_o    = oid_q;
  assign out_owner_o = oown_q;
  assign out_x_o     = ox_q;
  assign out_y_o     = oy_q;
  assign count_o     = ocnt_q;
  assign last_o      = olast_q;

  // Checks
  `CDET_ASSERT(a_fill_matches, $countones(valid_vec) == fill_q, "fill count off")
  `CDET_ASSERT(a_row_compact, (valid_vec & (valid_vec + Depth'(1))) == '0, "row has a gap")
  `CDET_ASSERT(a_steps_bound, steps_q <= fill_q, "scan beyond stored entries")

endmodule
